[hdl/msd_pkg.sv]
// shared types and constants for the mean and standard deviation block
`default_nettype none
package msd_pkg;
   localparam int FRAC_BITS = 16;
   localparam int RAD_W     = 64;
   localparam int ROOT_W    = 32;
   localparam int OUT_W     = 32;

   typedef logic [2:0] state_type;
   localparam state_type ST_LOAD = 3'd0;
   localparam state_type ST_PREP = 3'd1;
   localparam state_type ST_DIVI = 3'd2;
   localparam state_type ST_DIVM = 3'd3;
   localparam state_type ST_WALK = 3'd4;
   localparam state_type ST_DIVS = 3'd5;
   localparam state_type ST_SQRT = 3'd6;
   localparam state_type ST_EMIT = 3'd7;
endpackage
`default_nettype wire

[hdl/msd_if.sv]
// valid/ready channel interfaces for samples and results
`default_nettype none
interface msd_req_if #(parameter int SAMPLE_BITS = 16);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] sample_value;
   logic                   last_sample;
   modport source (output valid, sample_value, last_sample, input ready);
   modport sink (input valid, sample_value, last_sample, output ready);
endinterface

interface msd_rsp_if #(parameter int COUNT_BITS = 13);
   logic                  valid;
   logic                  ready;
   logic [31:0]           mean_q16;
   logic [31:0]           std_dev_q16;
   logic [COUNT_BITS-1:0] sample_count;
   modport source (output valid, mean_q16, std_dev_q16, sample_count, input ready);
   modport sink (input valid, mean_q16, std_dev_q16, sample_count, output ready);
endinterface
`default_nettype wire

[hdl/msd_div.sv]
// iterative restoring divider, one quotient bit per cycle
`default_nettype none
module msd_div #(
   parameter int DW = 64,
   parameter int NW = 13
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [DW-1:0] dividend,
   input  wire logic [NW-1:0] divisor,
   output logic               done,
   output logic [DW-1:0]      quotient,
   output logic [NW-1:0]      remainder
);
   localparam int CW = $clog2(DW + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0] dvd_ff, dvd_in;
   logic [DW-1:0] quo_ff, quo_in;
   logic [NW-1:0] rem_ff, rem_in;
   logic [NW-1:0] dsr_ff, dsr_in;
   logic [NW:0]   trial;
   logic          ge;

   always_comb begin
      trial   = {rem_ff, dvd_ff[DW-1]};
      ge      = trial >= {1'b0, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(DW);
         dvd_in  = dividend;
         quo_in  = '0;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? NW'(trial - {1'b0, dsr_ff}) : trial[NW-1:0];
         quo_in = {quo_ff[DW-2:0], ge};
         dvd_in = {dvd_ff[DW-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;
endmodule
`default_nettype wire

[hdl/msd_sqrt.sv]
// bitwise integer square root of a 64-bit radicand, one result bit per cycle
`default_nettype none
module msd_sqrt (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [msd_pkg::RAD_W-1:0]  radicand,
   output logic                            done,
   output logic [msd_pkg::ROOT_W-1:0]      root
);
   localparam int RW = msd_pkg::RAD_W;
   localparam int CW = $clog2(msd_pkg::ROOT_W + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [RW-1:0] val_ff, val_in;
   logic [RW-1:0] res_ff, res_in;
   logic [RW-1:0] bit_ff, bit_in;
   logic [RW-1:0] cand;

   always_comb begin
      cand    = res_ff + bit_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      val_in  = val_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(msd_pkg::ROOT_W);
         val_in  = radicand;
         res_in  = '0;
         bit_in  = {2'b01, {(RW-2){1'b0}}};
      end else if (busy_ff) begin
         if (val_ff >= cand) begin
            val_in = val_ff - cand;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      val_ff <= val_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign done = done_ff;
   assign root = res_ff[msd_pkg::ROOT_W-1:0];
endmodule
`default_nettype wire

[hdl/mean_and_std_deviation.sv]
// Population mean and standard deviation of a set of signed samples. Samples are
// taken one per cycle and written to an on-chip sample memory while a running sum
// is kept; the sample marked last closes the set. Closing a set runs these steps on
// the shared bit-serial divider (DIV_W is its dividend width, 77 at default settings)
// and the square root, in order: a divide for the integer mean, a divide for the
// Q16.16 mean, one memory read per stored sample to sum the squared deviations,
// a divide of that sum by the count and a 32-step square root. No sample is taken
// during that time; the finished result waits in an output register, so the next
// set may load while it is still pending. Samples beyond MAX_SAMPLES are dropped.
`default_nettype none
module mean_and_std_deviation #(
   parameter int MAX_SAMPLES = 4096,
   parameter int SAMPLE_BITS = 16
) (
   input wire logic clock,
   input wire logic reset,
   msd_req_if.sink   req_if,
   msd_rsp_if.source rsp_if
);
   localparam int SB      = SAMPLE_BITS;
   localparam int AW      = $clog2(MAX_SAMPLES);
   localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
   localparam int SUM_W   = SB + CNT_W;
   localparam int SQ_FULL = 2 * SB + CNT_W;
   localparam int SQ_W    = (SQ_FULL > 64) ? 64 : SQ_FULL;
   localparam int MEAN_DW = SUM_W + msd_pkg::FRAC_BITS;
   localparam int SD_DW   = SQ_W + 32;
   localparam int DIV_W   = (MEAN_DW > SD_DW) ? MEAN_DW : SD_DW;
   localparam int DW_W    = SB + 2;
   localparam int AD_W    = SB + 1;

   logic [SB-1:0] sample_store [MAX_SAMPLES];

   msd_pkg::state_type state_ff, state_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [SQ_W-1:0]         acc_ff, acc_in;
   logic [CNT_W-1:0]        rd_idx_ff, rd_idx_in;
   logic                    v1_ff, v1_in, v2_ff, v3_ff;
   logic [SB-1:0]           rd_data_ff;
   logic [AD_W-1:0]         ad_ff;
   logic [2*AD_W-1:0]       sq_ff;
   logic signed [AD_W-1:0]  fq_ff, fq_in;
   logic                    rem_nz_ff, rem_nz_in;
   logic [31:0]             mean_ff, mean_in;
   logic [31:0]             sd_ff, sd_in;
   logic                    out_valid_ff, out_valid_in;
   logic [31:0]             out_mean_ff, out_sd_ff;
   logic [CNT_W-1:0]        out_count_ff;
   logic                    emit;

   logic                    xfer;
   logic                    store_ok;
   logic signed [SB-1:0]    x;
   logic                    neg;
   logic [SUM_W-1:0]        abs_sum;
   logic                    div_start, div_done;
   logic [DIV_W-1:0]        div_dividend, quo;
   logic [CNT_W-1:0]        rem;
   logic                    sqrt_start, sqrt_done;
   logic [msd_pkg::ROOT_W-1:0] root;
   logic [AD_W-1:0]         fq_mag;
   logic signed [DW_W-1:0]  diff, adj;
   logic [AD_W-1:0]         adj_abs;
   logic                    walk_issued;

   assign x        = req_if.sample_value;
   assign xfer     = req_if.valid && req_if.ready;
   assign store_ok = count_ff < CNT_W'(MAX_SAMPLES);
   assign neg      = sum_ff[SUM_W-1];
   assign abs_sum  = neg ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
   assign fq_mag   = AD_W'(quo);
   assign walk_issued = rd_idx_ff == count_ff;
   assign emit     = (state_ff == msd_pkg::ST_EMIT) && (!out_valid_ff || rsp_if.ready);

   // deviation truncated toward zero, from floor mean and a nonzero-remainder flag
   always_comb begin
      diff    = DW_W'($signed(rd_data_ff)) - DW_W'(fq_ff);
      adj     = (rem_nz_ff && diff > 0) ? diff - DW_W'(1) : diff;
      adj_abs = adj[DW_W-1] ? AD_W'(-adj) : AD_W'(adj);
   end

   msd_div #(.DW(DIV_W), .NW(CNT_W)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (count_ff),
      .done      (div_done),
      .quotient  (quo),
      .remainder (rem)
   );

   msd_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (msd_pkg::RAD_W'(quo)),
      .done     (sqrt_done),
      .root     (root)
   );

   always_comb begin
      state_in     = state_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      acc_in       = acc_ff;
      rd_idx_in    = rd_idx_ff;
      v1_in        = 1'b0;
      fq_in        = fq_ff;
      rem_nz_in    = rem_nz_ff;
      mean_in      = mean_ff;
      sd_in        = sd_ff;
      out_valid_in = out_valid_ff && !rsp_if.ready;
      div_start    = 1'b0;
      div_dividend = DIV_W'(abs_sum);
      sqrt_start   = 1'b0;
      case (state_ff)
         msd_pkg::ST_LOAD: begin
            if (xfer) begin
               if (store_ok) begin
                  sum_in   = sum_ff + SUM_W'(x);
                  count_in = count_ff + 1'b1;
               end
               if (req_if.last_sample) begin
                  state_in = msd_pkg::ST_PREP;
               end
            end
         end
         msd_pkg::ST_PREP: begin
            div_start = 1'b1;
            state_in  = msd_pkg::ST_DIVI;
         end
         msd_pkg::ST_DIVI: begin
            if (div_done) begin
               rem_nz_in = rem != '0;
               if (!neg) begin
                  fq_in = $signed(fq_mag);
               end else if (rem != '0) begin
                  fq_in = $signed(-(fq_mag + AD_W'(1)));
               end else begin
                  fq_in = $signed(-fq_mag);
               end
               div_start    = 1'b1;
               div_dividend = DIV_W'({abs_sum, {msd_pkg::FRAC_BITS{1'b0}}});
               state_in     = msd_pkg::ST_DIVM;
            end
         end
         msd_pkg::ST_DIVM: begin
            if (div_done) begin
               mean_in   = neg ? -quo[31:0] : quo[31:0];
               acc_in    = '0;
               rd_idx_in = '0;
               state_in  = msd_pkg::ST_WALK;
            end
         end
         msd_pkg::ST_WALK: begin
            if (!walk_issued) begin
               v1_in     = 1'b1;
               rd_idx_in = rd_idx_ff + 1'b1;
            end
            if (v3_ff) begin
               acc_in = acc_ff + SQ_W'(sq_ff);
            end
            if (walk_issued && !v1_ff && !v2_ff && !v3_ff) begin
               div_start    = 1'b1;
               div_dividend = DIV_W'({acc_ff, 32'd0});
               state_in     = msd_pkg::ST_DIVS;
            end
         end
         msd_pkg::ST_DIVS: begin
            if (div_done) begin
               if ((quo >> msd_pkg::RAD_W) != '0) begin
                  sd_in    = 32'hFFFF_FFFF;
                  state_in = msd_pkg::ST_EMIT;
               end else begin
                  sqrt_start = 1'b1;
                  state_in   = msd_pkg::ST_SQRT;
               end
            end
         end
         msd_pkg::ST_SQRT: begin
            if (sqrt_done) begin
               sd_in    = root;
               state_in = msd_pkg::ST_EMIT;
            end
         end
         msd_pkg::ST_EMIT: begin
            if (emit) begin
               out_valid_in = 1'b1;
               sum_in       = '0;
               count_in     = '0;
               state_in     = msd_pkg::ST_LOAD;
            end
         end
         default: begin
            state_in = msd_pkg::ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= msd_pkg::ST_LOAD;
         sum_ff       <= '0;
         count_ff     <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         v1_ff        <= v1_in;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         out_valid_ff <= out_valid_in;
      end
      acc_ff    <= acc_in;
      rd_idx_ff <= rd_idx_in;
      fq_ff     <= fq_in;
      rem_nz_ff <= rem_nz_in;
      mean_ff   <= mean_in;
      sd_ff     <= sd_in;
      ad_ff     <= adj_abs;
      sq_ff     <= ad_ff * ad_ff;
      if (emit) begin
         out_mean_ff  <= mean_ff;
         out_sd_ff    <= sd_ff;
         out_count_ff <= count_ff;
      end
   end

   // sample memory: written while loading, read back during the walk
   always_ff @(posedge clock) begin
      if (xfer && store_ok) begin
         sample_store[count_ff[AW-1:0]] <= x;
      end
      rd_data_ff <= sample_store[rd_idx_ff[AW-1:0]];
   end

   assign req_if.ready        = state_ff == msd_pkg::ST_LOAD;
   assign rsp_if.valid        = out_valid_ff;
   assign rsp_if.mean_q16     = out_mean_ff;
   assign rsp_if.std_dev_q16  = out_sd_ff;
   assign rsp_if.sample_count = out_count_ff;

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_SAMPLES))
      else $error("sample count beyond memory depth");

   a_walk_idx : assert property (@(posedge clock) disable iff (reset)
      state_ff == msd_pkg::ST_WALK |-> rd_idx_ff <= count_ff)
      else $error("walk read index past sample count");

   a_pipe_in_walk : assert property (@(posedge clock) disable iff (reset)
      (v1_ff || v2_ff || v3_ff) |-> state_ff == msd_pkg::ST_WALK)
      else $error("squared deviation in flight outside the walk");

   a_emit_clears : assert property (@(posedge clock) disable iff (reset)
      emit |=> count_ff == '0 && sum_ff == '0 && rsp_if.valid)
      else $error("result emitted without clearing the set");
endmodule
`default_nettype wire
